### rtl/core/longest_subarray_target_sum_top_defines.svh
// assertion macros shared by the longest subarray target sum rtl
// no dependencies; files that check their logic include this header
`ifndef LONGEST_SUBARRAY_TARGET_SUM_TOP_DEFINES_SVH
`define LONGEST_SUBARRAY_TARGET_SUM_TOP_DEFINES_SVH
`ifndef SYNTHESIS
`define LSTS_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle check failed");
`define LSTS_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");
`else
`define LSTS_ASSERT_IMP(label, clk, rst, ante, cons)
`define LSTS_ASSERT_NXT(label, clk, rst, ante, cons)
`endif
`endif

### rtl/core/lsts_pkg.sv
// shared types and fixed field widths for the longest subarray target sum block
// no dependencies
package lsts_pkg;

   localparam int TGT_W = 11;
   localparam int OUT_W = 11;

   typedef struct packed {
      logic [OUT_W-1:0] removals;
      logic             found;
      logic             too_long;
   } rsp_type;

   typedef struct packed {
      logic [2:0] count;
      logic       full;
   } q_status_type;

endpackage

### rtl/core/lsts_pos_ram.sv
// first-position memory: one write port, one registered read port
// no dependencies
module lsts_pos_ram #(
   parameter int DEPTH = 1025,
   parameter int AW    = 11,
   parameter int DW    = 11
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [DW-1:0] wr_data,
   input  logic          rd_en,
   input  logic [AW-1:0] rd_addr,
   output logic [DW-1:0] rd_data
);

   logic [DW-1:0] mem [DEPTH];
   logic [DW-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/core/lsts_rsp_queue.sv
// four-entry result queue between the lookup pipeline and the rsp channel
// depends on lsts_pkg
module lsts_rsp_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  lsts_pkg::rsp_type      push_data,
   output logic                   out_valid,
   input  logic                   out_ready,
   output lsts_pkg::rsp_type      out_data,
   output lsts_pkg::q_status_type status
);

   lsts_pkg::rsp_type q_ff [4];
   logic [1:0]        wr_ptr_ff, wr_ptr_in;
   logic [1:0]        rd_ptr_ff, rd_ptr_in;
   logic [2:0]        count_ff, count_in;
   logic              pop;

   assign out_valid = (count_ff != 3'd0);
   assign out_data  = q_ff[rd_ptr_ff];
   assign pop       = out_valid && out_ready;

   always_comb begin
      wr_ptr_in = push ? (wr_ptr_ff + 2'd1) : wr_ptr_ff;
      rd_ptr_in = pop ? (rd_ptr_ff + 2'd1) : rd_ptr_ff;
      count_in  = count_ff + {2'b0, push} - {2'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 2'd0;
         rd_ptr_ff <= 2'd0;
         count_ff  <= 3'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign status.count = count_ff;
   assign status.full  = (count_ff == 3'd4);

endmodule

### rtl/core/longest_subarray_target_sum_top.sv
// result path: an accepted last-element beat passes the lookup stage register, then enters the result queue
// throughput: one element beat per cycle; req_ready drops only while four results are pending
// rate is set by the first-position memory: one lookup read and one insert write per beat
// the lookup read is registered, so the length compare runs one stage behind the accept
// reset: synchronous; clears sum, position, match state, target and the result queue
// the memory needs no clearing pass: entries above the running sum are never read
module longest_subarray_target_sum_top #(
   parameter int MAX_LEN = 1024
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_we,
   input  logic [lsts_pkg::TGT_W-1:0]  csr_wdata,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic                        req_element,
   input  logic                        req_is_last,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [lsts_pkg::OUT_W-1:0]  rsp_removals,
   output logic                        rsp_found,
   output logic                        rsp_too_long
);

   localparam int CW = $clog2(MAX_LEN + 1);
   localparam int SW = (CW > lsts_pkg::TGT_W) ? CW : lsts_pkg::TGT_W;

   // configuration
   logic [lsts_pkg::TGT_W-1:0] target_ff;

   // accept stage state
   logic [CW-1:0] sum_ff, sum_in;
   logic [CW-1:0] pos_ff, pos_in;
   logic          ovf_ff, ovf_in;

   // lookup stage
   logic          s1_valid_ff;
   logic          s1_last_ff;
   logic          s1_cand_ff;
   logic          s1_need_zero_ff;
   logic          s1_ovf_ff;
   logic [CW-1:0] s1_pos_ff;

   logic [CW-1:0] longest_ff, longest_in;
   logic          seen_ff, seen_in;

   logic          accept;
   logic          full_len;
   logic [CW-1:0] new_sum;
   logic [CW-1:0] new_pos;
   logic [SW-1:0] need_full;
   logic [CW-1:0] need;
   logic          cand;
   logic [CW-1:0] rd_data;
   logic [CW-1:0] first_pos;
   logic [CW-1:0] len;
   logic [CW-1:0] longest_next;
   logic          seen_next;
   logic [CW-1:0] removals_full;
   logic          push;
   logic [2:0]    pending;

   lsts_pkg::rsp_type      push_data;
   lsts_pkg::rsp_type      out_data;
   lsts_pkg::q_status_type q_status;

   // a new beat may be taken while up to three results wait, lookup stage included
   assign pending   = q_status.count + {2'b0, s1_valid_ff & s1_last_ff};
   assign req_ready = (pending < 3'd4);
   assign accept    = req_valid && req_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         target_ff <= '0;
      end else if (csr_we) begin
         target_ff <= csr_wdata;
      end
   end

   // accept stage: prefix sum, lookup address, insert of a newly reached sum
   always_comb begin
      full_len  = (pos_ff == CW'(MAX_LEN));
      new_sum   = sum_ff + CW'(req_element);
      new_pos   = pos_ff + CW'(1);
      need_full = SW'(new_sum) - SW'(target_ff);
      need      = need_full[CW-1:0];
      // the sum just reached is not in the memory yet, so an empty stretch never counts
      cand      = !full_len && (SW'(new_sum) >= SW'(target_ff))
                  && !((target_ff == '0) && req_element);
   end

   always_comb begin
      sum_in = sum_ff;
      pos_in = pos_ff;
      ovf_in = ovf_ff;
      if (accept) begin
         if (req_is_last) begin
            sum_in = '0;
            pos_in = '0;
            ovf_in = 1'b0;
         end else if (full_len) begin
            ovf_in = 1'b1;
         end else begin
            sum_in = new_sum;
            pos_in = new_pos;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff      <= '0;
         pos_ff      <= '0;
         ovf_ff      <= 1'b0;
         s1_valid_ff <= 1'b0;
      end else begin
         sum_ff      <= sum_in;
         pos_ff      <= pos_in;
         ovf_ff      <= ovf_in;
         s1_valid_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_last_ff      <= req_is_last;
         s1_cand_ff      <= cand;
         s1_need_zero_ff <= (need == '0);
         s1_ovf_ff       <= ovf_ff | full_len;
         s1_pos_ff       <= full_len ? pos_ff : new_pos;
      end
   end

   // sum zero sits at position zero and is never stored
   lsts_pos_ram #(
      .DEPTH (MAX_LEN + 1),
      .AW    (CW),
      .DW    (CW)
   ) u_pos_ram (
      .clock   (clock),
      .wr_en   (accept && !full_len && req_element),
      .wr_addr (new_sum),
      .wr_data (new_pos),
      .rd_en   (accept),
      .rd_addr (need),
      .rd_data (rd_data)
   );

   // lookup stage: stretch length and running maximum
   always_comb begin
      first_pos     = s1_need_zero_ff ? '0 : rd_data;
      len           = s1_pos_ff - first_pos;
      longest_next  = (s1_cand_ff && (len > longest_ff)) ? len : longest_ff;
      seen_next     = seen_ff | s1_cand_ff;
      removals_full = s1_pos_ff - longest_next;
   end

   always_comb begin
      longest_in = longest_ff;
      seen_in    = seen_ff;
      if (s1_valid_ff) begin
         if (s1_last_ff) begin
            longest_in = '0;
            seen_in    = 1'b0;
         end else begin
            longest_in = longest_next;
            seen_in    = seen_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         longest_ff <= '0;
         seen_ff    <= 1'b0;
      end else begin
         longest_ff <= longest_in;
         seen_ff    <= seen_in;
      end
   end

   always_comb begin
      push      = s1_valid_ff && s1_last_ff;
      push_data = '0;
      priority if (s1_ovf_ff) begin
         push_data.too_long = 1'b1;
      end else if (seen_next) begin
         push_data.removals = lsts_pkg::OUT_W'(removals_full);
         push_data.found    = 1'b1;
      end
   end

   lsts_rsp_queue u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_data  (out_data),
      .status    (q_status)
   );

   assign rsp_removals = out_data.removals;
   assign rsp_found    = out_data.found;
   assign rsp_too_long = out_data.too_long;

`include "longest_subarray_target_sum_top_defines.svh"

   `LSTS_ASSERT_IMP(a_no_queue_overrun, clock, reset, push, !q_status.full)
   `LSTS_ASSERT_IMP(a_sum_within_pos, clock, reset, 1'b1, sum_ff <= pos_ff)
   `LSTS_ASSERT_IMP(a_pos_bounded, clock, reset, 1'b1, pos_ff <= CW'(MAX_LEN))
   `LSTS_ASSERT_NXT(a_last_reaches_lookup, clock, reset, accept && req_is_last,
                    s1_valid_ff && s1_last_ff && (pos_ff == '0))
   `LSTS_ASSERT_IMP(a_found_excludes_long, clock, reset, rsp_valid,
                    !(rsp_found && rsp_too_long))

endmodule

### dv/tb_longest_subarray_target_sum_top.sv
// self-checking testbench for longest_subarray_target_sum_top: streams binary arrays,
// predicts the trim result of each array and checks every result beat in order
// depends on lsts_pkg and the longest_subarray_target_sum_top rtl
module tb_longest_subarray_target_sum_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int TGT_W = lsts_pkg::TGT_W;
   localparam int OUT_W = lsts_pkg::OUT_W;
   localparam int ARR_MAX = 1024;
   localparam int MAX_SHOWN = 10;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             csr_we = 1'b0;
   logic [TGT_W-1:0] csr_wdata = '0;
   logic             req_valid = 1'b0;
   logic             req_ready;
   logic             req_element = 1'b0;
   logic             req_is_last = 1'b0;
   logic             rsp_valid;
   logic             rsp_ready = 1'b0;
   logic [OUT_W-1:0] rsp_removals;
   logic             rsp_found;
   logic             rsp_too_long;

   // predictor state for the current array
   logic [TGT_W-1:0] tgt_sum;
   logic [10:0]      run_sum;
   logic [10:0]      pos_count;
   logic [10:0]      best_len;
   logic             match_seen;
   logic             len_overflow;
   logic [10:0]      first_pos [0:ARR_MAX];
   logic             prefix_seen [0:ARR_MAX];

   lsts_pkg::rsp_type expected_trims[$];

   int  fail_count = 0;
   int  arrays_sent = 0;
   int  elements_sent = 0;
   int  results_checked = 0;
   int  targets_written = 0;
   bit  req_idle = 1'b1;
   bit  rsp_idle = 1'b1;
   int  rsp_hold = 0;
   int  rsp_wait = 0;

   longest_subarray_target_sum_top u_dut (
      .clock        (clock),
      .reset        (reset),
      .csr_we       (csr_we),
      .csr_wdata    (csr_wdata),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_element  (req_element),
      .req_is_last  (req_is_last),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_removals (rsp_removals),
      .rsp_found    (rsp_found),
      .rsp_too_long (rsp_too_long)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   initial begin
      #20_000_000;
      $display("timeout with %0d results still pending", expected_trims.size());
      $display("== FAIL ==");
      $finish;
   end

   function automatic void clear_array();
      run_sum = '0;
      pos_count = '0;
      best_len = '0;
      match_seen = 1'b0;
      len_overflow = 1'b0;
      foreach (prefix_seen[i]) prefix_seen[i] = 1'b0;
      prefix_seen[0] = 1'b1;
      first_pos[0] = '0;
   endfunction

   // returns 1 when the element closes an array, with the expected trim result
   function automatic logic consume_element(input logic elem, input logic is_last,
                                            output lsts_pkg::rsp_type trim);
      logic [10:0] need;
      logic [10:0] span;
      trim = '0;
      if (pos_count >= ARR_MAX) begin
         len_overflow = 1'b1;
      end else begin
         run_sum = run_sum + elem;
         pos_count = pos_count + 1'b1;
         if (run_sum >= tgt_sum) begin
            need = run_sum - tgt_sum;
            // lookup precedes the insert, so an empty stretch never matches
            if (prefix_seen[need]) begin
               span = pos_count - first_pos[need];
               match_seen = 1'b1;
               if (span > best_len) best_len = span;
            end
         end
         if (!prefix_seen[run_sum]) begin
            prefix_seen[run_sum] = 1'b1;
            first_pos[run_sum] = pos_count;
         end
      end
      if (!is_last) return 1'b0;
      if (len_overflow) begin
         trim.too_long = 1'b1;
      end else if (match_seen) begin
         trim.removals = pos_count - best_len;
         trim.found = 1'b1;
      end
      clear_array();
      return 1'b1;
   endfunction

   // receiver: random stall after each beat while rsp_idle is set, plus an optional long hold-off
   initial begin
      forever begin
         @(posedge clock);
         if (rsp_valid && rsp_ready) rsp_wait = rsp_idle ? $urandom_range(0, 19) : 0;
         if (rsp_hold > 0) begin
            rsp_hold--;
            rsp_ready <= 1'b0;
         end else if (rsp_wait > 0) begin
            rsp_wait--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      lsts_pkg::rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_trims.size() == 0) begin
            fail_count++;
            if (fail_count <= MAX_SHOWN)
               $display("unexpected result beat: removals=%0d found=%b too_long=%b",
                        rsp_removals, rsp_found, rsp_too_long);
         end else begin
            want = expected_trims.pop_front();
            results_checked++;
            if (rsp_removals !== want.removals || rsp_found !== want.found ||
                rsp_too_long !== want.too_long) begin
               fail_count++;
               if (fail_count <= MAX_SHOWN)
                  $display({"mismatch: expected removals=%0d found=%b too_long=%b,",
                            " got removals=%0d found=%b too_long=%b"},
                           want.removals, want.found, want.too_long,
                           rsp_removals, rsp_found, rsp_too_long);
            end
         end
      end
   end

   task automatic send_beat(input logic elem, input logic is_last);
      int unsigned gap;
      lsts_pkg::rsp_type trim;
      gap = req_idle ? $urandom_range(0, 19) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_element <= elem;
      req_is_last <= is_last;
      do @(posedge clock); while (!req_ready);
      elements_sent++;
      if (consume_element(elem, is_last, trim)) begin
         expected_trims.insert(expected_trims.size(), trim);
         arrays_sent++;
      end
   endtask

   task automatic send_array(input int len, input int ones_pct);
      for (int i = 0; i < len; i++)
         send_beat($urandom_range(0, 99) < ones_pct, i == len - 1);
   endtask

   task automatic send_bits(input logic [31:0] bits, input int len);
      for (int i = 0; i < len; i++)
         send_beat(bits[i], i == len - 1);
   endtask

   // target only changes between arrays, once all results are back
   task automatic set_target(input logic [TGT_W-1:0] value);
      req_valid <= 1'b0;
      while (expected_trims.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      csr_we <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      tgt_sum = value;
      targets_written++;
   endtask

   task automatic test_directed();
      // reset target of zero: a lone zero matches, a lone one has no prior prefix
      send_bits(32'b0, 1);
      send_bits(32'b1, 1);
      set_target(11'd2);
      send_bits(32'b011010, 6);
      // target above the running sum
      set_target(11'd3);
      send_bits(32'b11, 2);
      set_target(11'd1024);
      send_bits(32'b011, 3);
      set_target(11'd0);
      send_bits(32'b0000, 4);
      send_bits(32'b101, 3);
   endtask

   task automatic test_max_length();
      req_idle = 1'b0;
      // table fills to the last position, then one ignored beat and a last beat past it
      set_target(11'd1024);
      send_array(ARR_MAX + 2, 100);
      set_target(11'd2047);
      send_array(5, 100);
      req_idle = 1'b1;
   endtask

   task automatic test_backpressure();
      req_idle = 1'b0;
      rsp_idle = 1'b0;
      set_target(11'd1);
      rsp_hold = 300;
      for (int i = 0; i < 30; i++)
         send_array($urandom_range(1, 3), 50);
      req_idle = 1'b1;
      rsp_idle = 1'b1;
   endtask

   task automatic test_random(input int element_budget);
      int stop_at;
      int pick;
      int len;
      int pct;
      stop_at = elements_sent + element_budget;
      while (elements_sent < stop_at) begin
         pick = $urandom_range(0, 9);
         if (pick == 0)      set_target(11'd0);
         else if (pick == 1) set_target(TGT_W'($urandom_range(17, 40)));
         else if (pick == 2) set_target(TGT_W'($urandom_range(0, 2047)));
         else                set_target(TGT_W'($urandom_range(1, 10)));
         pick = $urandom_range(0, 3);
         req_idle = pick[0];
         rsp_idle = pick[1];
         for (int a = 0; a < 8; a++) begin
            len = ($urandom_range(0, 9) < 7) ? $urandom_range(1, 16)
                                             : $urandom_range(17, 60);
            pick = $urandom_range(0, 9);
            pct = (pick == 0) ? 0 : (pick == 1) ? 100 : $urandom_range(5, 95);
            send_array(len, pct);
         end
      end
      req_idle = 1'b1;
      rsp_idle = 1'b1;
   endtask

   initial begin
      tgt_sum = '0;
      foreach (first_pos[i]) first_pos[i] = '0;
      clear_array();
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed();
      test_max_length();
      test_backpressure();
      test_random(250);

      req_valid <= 1'b0;
      while (expected_trims.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);

      $display("covered %0d arrays of %0d elements, %0d result beats checked",
               arrays_sent, elements_sent, results_checked);
      $display("%0d target writes incl. 0, 1024 and 2047; overlong array, long receiver hold",
               targets_written);
      if (fail_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("%0d failures", fail_count);
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

### longest_subarray_target_sum_top.f
+incdir+rtl/core
rtl/core/lsts_pkg.sv
rtl/core/lsts_pos_ram.sv
rtl/core/lsts_rsp_queue.sv
rtl/core/longest_subarray_target_sum_top.sv
dv/tb_longest_subarray_target_sum_top.sv
